/* rtl/dq_pkg.sv */
`timescale 1ns / 1ps

package dq_pkg;

  // Queue geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);

  // Fixed field widths of the request and response beats.
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int OFFS_W  = 4;
  localparam int OCC_W   = 5;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [AW-1:0]         slot_idx_t;
  typedef logic [CW-1:0]         count_t;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_READ_INDEX = 3'd6,
    MODE_FIND       = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data_out;
    status_t            status;
    logic [OFFS_W-1:0]  offset;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  // Commands broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic   shift_back;
    logic   shift_front;
    logic   wr_back;
    logic   load_probe;
    logic   shift_probe;
    word_t  value;
    count_t count;
  } cell_ctl_t;

endpackage

/* rtl/double_ended_queue_unit.sv */
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH words held in a chain of cells, with
// the entry at the front in the first cell.
// Request channel (req_valid, req_stall, req): one beat asks for a push or
// pop at either end, a peek at either end, a read at a position from the
// front, or a search for the first entry equal to a value.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one beat for each
// request, with the data word, a status, the match offset and the occupancy
// after the operation.
// Push, pop front and peek front touch the first cell or the tail slot and
// answer in the cycle after acceptance; a new request can follow every
// cycle while no response beat is held. Pop back, peek back, read index
// and find copy the chain into a probe chain that moves one cell toward
// the front each cycle until the position read (the last entry for the
// back, the match or last entry for find) reaches the first cell. The
// request side stalls while a scan runs.
// The response is registered. While rsp_stall holds a beat, the held beat
// stays and no new request is taken.
// Synchronous reset empties the queue; the stored words are not cleared.
module double_ended_queue_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  dq_pkg::req_t req,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output dq_pkg::rsp_t rsp
);
  import dq_pkg::*;

  cell_ctl_t ctl;
  word_t     cell_data  [DEPTH];
  word_t     cell_probe [DEPTH];

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .head_data  (cell_data[0]),
    .head_probe (cell_probe[0]),
    .ctl        (ctl)
  );

  // The chain: each cell takes data from its neighbors; the first cell takes the pushed word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t prev_data;
    word_t next_data;
    word_t next_probe;

    if (i == 0) begin : g_head
      assign prev_data = ctl.value;
    end else begin : g_body
      assign prev_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_data  = '0;
      assign next_probe = '0;
    end else begin : g_link
      assign next_data  = cell_data[i+1];
      assign next_probe = cell_probe[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (AW'(i)),
      .prev_data  (prev_data),
      .next_data  (next_data),
      .next_probe (next_probe),
      .data       (cell_data[i]),
      .probe      (cell_probe[i])
    );
  end

endmodule

/* rtl/dq_cell.sv */
`timescale 1ns / 1ps

module dq_cell (
  input  logic              clk,
  input  dq_pkg::cell_ctl_t ctl,
  input  dq_pkg::slot_idx_t idx,
  input  dq_pkg::word_t     prev_data,
  input  dq_pkg::word_t     next_data,
  input  dq_pkg::word_t     next_probe,
  output dq_pkg::word_t     data,
  output dq_pkg::word_t     probe
);
  import dq_pkg::*;

  logic at_tail;

  // This cell is the first free slot behind the last entry.
  assign at_tail = (ctl.count == CW'(idx));

  // Entry register: shifts toward the back on a front push, toward the
  // front on a front pop, and takes the pushed word at the tail.
  always_ff @(posedge clk) begin
    if (ctl.shift_back) begin
      data <= prev_data;
    end else if (ctl.shift_front) begin
      data <= next_data;
    end else if (ctl.wr_back && at_tail) begin
      data <= ctl.value;
    end
  end

  // Probe register: a copy of the entries that walks toward the front
  // one cell per cycle during a scan.
  always_ff @(posedge clk) begin
    if (ctl.load_probe) begin
      probe <= data;
    end else if (ctl.shift_probe) begin
      probe <= next_probe;
    end
  end

endmodule

/* rtl/dq_ctrl.sv */
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  dq_pkg::req_t      req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output dq_pkg::rsp_t      rsp,
  input  dq_pkg::word_t     head_data,
  input  dq_pkg::word_t     head_probe,
  output dq_pkg::cell_ctl_t ctl
);
  import dq_pkg::*;

  state_t    state, state_next;
  count_t    count, count_next;
  slot_idx_t k, k_next;
  slot_idx_t target, target_next;
  word_t     key, key_next;
  mode_t     op, op_next;
  rsp_t      rsp_next;
  logic      rsp_load;
  logic      accept;
  logic      start_scan;
  logic      scan_hit;
  logic      scan_last;
  logic      full;
  logic      empty;
  word_t     req_word;

  assign req_word = DATA_WIDTH'(req.value);
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign accept   = req_valid && !req_stall;
  assign scan_hit  = (op == MODE_FIND) ? (head_probe == key) : (k == target);
  assign scan_last = (k == target);

  // Requests wait while a scan runs or a held response beat is not taken.
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && start_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs, cell commands and datapath updates.
  always_comb begin
    start_scan  = 1'b0;
    rsp_load    = 1'b0;
    rsp_next    = '{data_out: '0, status: ST_OK, offset: '0, occupancy: '0};
    count_next  = count;
    k_next      = k;
    target_next = target;
    key_next    = key;
    op_next     = op;
    ctl         = '{shift_back: 1'b0, shift_front: 1'b0, wr_back: 1'b0,
                    load_probe: 1'b0, shift_probe: 1'b0, value: req_word,
                    count: count};
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next     = req.mode;
          key_next    = req_word;
          k_next      = '0;
          target_next = AW'(count - CW'(1));
          rsp_load    = 1'b1;
          case (req.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (full) begin
                rsp_next.status = ST_FULL;
              end else begin
                ctl.shift_back = (req.mode == MODE_PUSH_FRONT);
                ctl.wr_back    = (req.mode == MODE_PUSH_BACK);
                count_next     = count + CW'(1);
              end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                rsp_next.data_out = VALUE_W'(head_data);
                if (req.mode == MODE_POP_FRONT) begin
                  ctl.shift_front = 1'b1;
                  count_next      = count - CW'(1);
                end
              end
            end
            MODE_READ_INDEX: begin
              if (int'(req.position) >= int'(count)) begin
                rsp_next.status = ST_RANGE;
              end else begin
                start_scan  = 1'b1;
                target_next = AW'(req.position);
              end
            end
            default: begin
              // Pop back, peek back and find walk the probe chain.
              if (empty) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                start_scan = 1'b1;
              end
            end
          endcase
          if (start_scan) begin
            rsp_load       = 1'b0;
            ctl.load_probe = 1'b1;
          end
          rsp_next.occupancy = OCC_W'(count_next);
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          rsp_load = 1'b1;
          if (op == MODE_FIND) begin
            rsp_next.offset = OFFS_W'(k);
          end else begin
            rsp_next.data_out = VALUE_W'(head_probe);
          end
          if (op == MODE_POP_BACK) begin
            count_next = count - CW'(1);
          end
        end else if (scan_last) begin
          // Find reached the last entry without a match.
          rsp_load        = 1'b1;
          rsp_next.status = ST_EMPTY;
        end else begin
          ctl.shift_probe = 1'b1;
          k_next          = k + AW'(1);
        end
        rsp_next.occupancy = OCC_W'(count_next);
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Scan context and response payload.
  always_ff @(posedge clk) begin
    k      <= k_next;
    target <= target_next;
    key    <= key_next;
    op     <= op_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* rtl/dq_checker.sv */
`timescale 1ns / 1ps

module dq_checker (
  input logic         clk,
  input logic         rst,
  input logic         req_valid,
  input logic         req_stall,
  input dq_pkg::req_t req,
  input logic         rsp_valid,
  input logic         rsp_stall,
  input dq_pkg::rsp_t rsp
);
  import dq_pkg::*;

  // A held response beat stays until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response beat dropped while stalled");

  // Occupancy never exceeds the capacity.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(rsp.occupancy) <= DEPTH))
    else $error("occupancy beyond capacity");

  // Any failed operation returns a zero data word and zero offset.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.data_out == '0) && (rsp.offset == '0))
    else $error("failed operation returned data");

  // A dropped push is reported only when the queue is full.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> (int'(rsp.occupancy) == DEPTH))
    else $error("full status with free space");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import dq_pkg::*;

  // A scan stops at the last entry at the latest, so a long quiet stretch means a hang.
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int PRINT_LIMIT  = 30;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;

  // Expected response beats, oldest first.
  rsp_t expected_rsp_q[$];

  // Shadow copy of the deque contents.
  word_t     shadow_ring[DEPTH] = '{default: '0};
  slot_idx_t shadow_front = '0;
  count_t    shadow_count = '0;

  double_ended_queue_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Slot of the entry k places behind the front.
  function automatic slot_idx_t slot_of(input int k);
    return slot_idx_t'((int'(shadow_front) + k) % DEPTH);
  endfunction

  // Applies one request to the shadow deque and returns the response it owes.
  function automatic rsp_t predict_deque(input req_t r);
    rsp_t o;
    logic hit;
    int   k;
    o        = '0;
    o.status = ST_OK;
    hit      = 1'b0;
    case (r.mode)
      MODE_PUSH_FRONT: begin
        if (int'(shadow_count) >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          shadow_front              = slot_of(DEPTH - 1);
          shadow_ring[shadow_front] = word_t'(r.value);
          shadow_count++;
        end
      end
      MODE_PUSH_BACK: begin
        if (int'(shadow_count) >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          shadow_ring[slot_of(int'(shadow_count))] = word_t'(r.value);
          shadow_count++;
        end
      end
      MODE_POP_FRONT: begin
        if (int'(shadow_count) == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.data_out   = shadow_ring[shadow_front];
          shadow_front = slot_of(1);
          shadow_count--;
        end
      end
      MODE_POP_BACK: begin
        if (int'(shadow_count) == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.data_out = shadow_ring[slot_of(int'(shadow_count) - 1)];
          shadow_count--;
        end
      end
      MODE_PEEK_FRONT: begin
        if (int'(shadow_count) == 0) o.status = ST_EMPTY;
        else o.data_out = shadow_ring[shadow_front];
      end
      MODE_PEEK_BACK: begin
        if (int'(shadow_count) == 0) o.status = ST_EMPTY;
        else o.data_out = shadow_ring[slot_of(int'(shadow_count) - 1)];
      end
      MODE_READ_INDEX: begin
        if (int'(r.position) >= int'(shadow_count)) o.status = ST_RANGE;
        else o.data_out = shadow_ring[slot_of(int'(r.position))];
      end
      default: begin
        // Find reports the first equal entry counted from the front.
        o.status = ST_EMPTY;
        for (k = 0; k < int'(shadow_count) && !hit; k++) begin
          if (shadow_ring[slot_of(k)] == word_t'(r.value)) begin
            hit      = 1'b1;
            o.status = ST_OK;
            o.offset = k[OFFS_W-1:0];
          end
        end
      end
    endcase
    o.occupancy = shadow_count;
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) $display("tb: mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  // Sends one request beat, holding it until it is taken, and records the
  // response it should produce.
  task automatic send_req(input mode_t m, input logic [VALUE_W-1:0] v,
                          input int p);
    req_t r;
    r.mode     = m;
    r.value    = v;
    r.position = POS_W'(p);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsp_q.push_back(predict_deque(r));
  endtask

  // Data words with many repeats and the all-zero and all-one extremes.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0:       return VALUE_W'($urandom_range(7));
      1:       return ($urandom_range(1) != 0) ? '1 : VALUE_W'(1) << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_queue();
    send_req(MODE_POP_FRONT, $urandom(), $urandom_range(15));
    send_req(MODE_POP_BACK, $urandom(), $urandom_range(15));
    send_req(MODE_PEEK_FRONT, $urandom(), $urandom_range(15));
    send_req(MODE_PEEK_BACK, $urandom(), $urandom_range(15));
    send_req(MODE_READ_INDEX, $urandom(), 0);
    send_req(MODE_FIND, '0, 0);
  endtask

  // Fill from both ends until full, then push at each end onto the full queue.
  task automatic test_fill_to_full();
    logic [VALUE_W-1:0] v;
    int i;
    for (i = 0; i < DEPTH; i++) begin
      v = (i == 0) ? '1 : (i == 1) ? '0 : $urandom();
      send_req((i % 2 == 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, v, $urandom_range(15));
    end
    send_req(MODE_PUSH_FRONT, $urandom(), $urandom_range(15));
    send_req(MODE_PUSH_BACK, $urandom(), $urandom_range(15));
  endtask

  // Reads at both ends and the far index of a full queue, a hit at the last
  // position, a miss, and a pop from each end.
  task automatic test_full_reads();
    send_req(MODE_READ_INDEX, $urandom(), 15);
    send_req(MODE_READ_INDEX, $urandom(), 0);
    send_req(MODE_PEEK_FRONT, $urandom(), $urandom_range(15));
    send_req(MODE_PEEK_BACK, $urandom(), $urandom_range(15));
    send_req(MODE_FIND, shadow_ring[slot_of(int'(shadow_count) - 1)], $urandom_range(15));
    send_req(MODE_FIND, 32'h1234_5678, $urandom_range(15));
    send_req(MODE_POP_FRONT, $urandom(), $urandom_range(15));
    send_req(MODE_POP_BACK, $urandom(), $urandom_range(15));
  endtask

  // Random traffic that alternately fills and drains the queue, so that both
  // the empty and the full boundary are crossed many times.
  task automatic test_random_traffic(input int n_items, input int idle_p, input int stall_p);
    int  i;
    int  roll;
    int  push_cut;
    logic [VALUE_W-1:0] v;
    send_idle_pct = idle_p;
    stall_pct     = stall_p;
    for (i = 0; i < n_items; i++) begin
      push_cut = (((i / 48) % 2) == 0) ? 35 : 12;
      roll     = $urandom_range(99);
      v        = pick_value();
      if (roll < push_cut) begin
        send_req(($urandom_range(1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, v,
                 $urandom_range(15));
      end else if (roll < 50) begin
        send_req(($urandom_range(1) != 0) ? MODE_POP_FRONT : MODE_POP_BACK, v,
                 $urandom_range(15));
      end else if (roll < 62) begin
        send_req(($urandom_range(1) != 0) ? MODE_PEEK_FRONT : MODE_PEEK_BACK, v,
                 $urandom_range(15));
      end else if (roll < 80) begin
        send_req(MODE_READ_INDEX, v, $urandom_range(15));
      end else begin
        // Mostly search for a word that is held somewhere in the queue.
        if (shadow_count != 0 && $urandom_range(2) != 0)
          v = shadow_ring[slot_of($urandom_range(int'(shadow_count) - 1))];
        send_req(MODE_FIND, v, $urandom_range(15));
      end
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare every response beat against the oldest expectation.
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("response beat with nothing expected");
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.data_out !== want.data_out)
          report_mismatch($sformatf("data_out %h, expected %h", rsp.data_out, want.data_out));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
        if (rsp.offset !== want.offset)
          report_mismatch($sformatf("offset %0d, expected %0d", rsp.offset, want.offset));
        if (rsp.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d",
                                    rsp.occupancy, want.occupancy));
      end
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: timeout with %0d responses outstanding", expected_rsp_q.size());
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_fill_to_full();
    test_full_reads();
    test_random_traffic(380, 0, 0);
    test_random_traffic(380, 57, 0);
    test_random_traffic(380, 0, 57);
    test_random_traffic(380, 35, 35);
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
